// File: hw/rtl/tsnb_pkg.sv
// Shared types, register codes, calendar constants and helper functions
// for the trading session boundary block. No dependencies.
`timescale 1ns / 1ps

package tsnb_pkg;

	// Field widths
	localparam int WINDOW_W  = 22;
	localparam int MINUTE_W  = 11;
	localparam int COUNT_W   = 3;
	localparam int SECONDS_W = 32;
	localparam int DAY_W     = 3;
	localparam int SESSION_W = 2;
	localparam int REG_IDX_W = 3;
	localparam int MIN_OFF_W = 17;
	localparam int DAY_OFF_W = 18;

	// Time constants
	localparam int unsigned MINUTE_SECONDS = 60;
	localparam int unsigned DAY_SECONDS    = 86400;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_SESSION_COUNT    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SESSION_WINDOW_0 = 3'd1;

	// Register reset values
	localparam logic [COUNT_W-1:0]  SESSION_COUNT_RESET = 3'd1;
	localparam logic [WINDOW_W-1:0] WINDOW_RESET        = '0;

	// Weekday codes
	localparam logic [DAY_W-1:0] DAY_SUNDAY   = 3'd0;
	localparam logic [DAY_W-1:0] DAY_MONDAY   = 3'd1;
	localparam logic [DAY_W-1:0] DAY_FRIDAY   = 3'd5;
	localparam logic [DAY_W-1:0] DAY_SATURDAY = 3'd6;

	// Boundary kinds
	localparam logic KIND_OPEN  = 1'b0;
	localparam logic KIND_CLOSE = 1'b1;

	typedef struct packed {
		logic                 kind;
		logic [SECONDS_W-1:0] seconds;
		logic [SESSION_W-1:0] number;
	} result_t;

	function automatic logic is_weekday(input logic [DAY_W-1:0] day);
		return day inside {[DAY_MONDAY:DAY_FRIDAY]};
	endfunction

	// Seconds from today's midnight to the next weekday's midnight
	function automatic logic [DAY_OFF_W-1:0] next_weekday_offset(input logic [DAY_W-1:0] day);
		logic [DAY_OFF_W-1:0] off;
		case (day)
			DAY_FRIDAY:   off = DAY_OFF_W'(3 * DAY_SECONDS);
			DAY_SATURDAY: off = DAY_OFF_W'(2 * DAY_SECONDS);
			default:      off = DAY_OFF_W'(DAY_SECONDS);
		endcase
		return off;
	endfunction

	function automatic logic [MIN_OFF_W-1:0] minute_offset(input logic [MINUTE_W-1:0] minute);
		return MIN_OFF_W'(minute) * MIN_OFF_W'(MINUTE_SECONDS);
	endfunction

	function automatic logic [MINUTE_W-1:0] start_minute(input logic [WINDOW_W-1:0] w);
		return w[WINDOW_W-1:MINUTE_W];
	endfunction

	function automatic logic [MINUTE_W-1:0] stop_minute(input logic [WINDOW_W-1:0] w);
		return w[MINUTE_W-1:0];
	endfunction

endpackage

// File: hw/rtl/trading_session_next_boundary.sv
// Top level of the trading session boundary block: input register, search
// logic and result register. Depends on tsnb_pkg, tsnb_cfg and tsnb_eval.
`timescale 1ns / 1ps

// Takes one item per clock cycle and returns one result per item, in order,
// via the input register and then the result register. The whole search
// (per-session open and close sums, compares against now, and the in-order
// pick) is one combinational pass between those two registers, so the rate
// is one item every cycle unless the output stalls. A stalled output holds
// its result while a new item still enters the input register; in_ready
// drops only when both registers are full and out_ready is low. The user must
// write configuration registers through cfg_write, cfg_index and cfg_data
// only while no item is in flight; the block itself does not enforce this.
module trading_session_next_boundary
	import tsnb_pkg::*;
#(
	parameter int MAX_SESSIONS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [WINDOW_W-1:0]  cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [SECONDS_W-1:0] now_seconds,
	input  logic [SECONDS_W-1:0] midnight_seconds,
	input  logic [DAY_W-1:0]     weekday,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 boundary_kind,
	output logic [SECONDS_W-1:0] boundary_seconds,
	output logic [SESSION_W-1:0] session_number
);

	logic [COUNT_W-1:0]   session_count;
	logic [WINDOW_W-1:0]  session_window [MAX_SESSIONS];

	logic                 valid_s1;
	logic [SECONDS_W-1:0] now_s1;
	logic [SECONDS_W-1:0] mid_s1;
	logic [DAY_W-1:0]     day_s1;
	logic                 valid_s2;
	result_t              result_s2;
	result_t              result;
	logic                 load_s2;

	tsnb_cfg #(
		.MAX_SESSIONS(MAX_SESSIONS)
	) u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.session_count (session_count),
		.session_window(session_window)
	);

	// Advance when the result register is free or being emptied
	assign load_s2  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || load_s2;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			now_s1 <= now_seconds;
			mid_s1 <= midnight_seconds;
			day_s1 <= weekday;
		end
	end

	tsnb_eval #(
		.MAX_SESSIONS(MAX_SESSIONS)
	) u_eval (
		.now_seconds     (now_s1),
		.midnight_seconds(mid_s1),
		.weekday         (day_s1),
		.session_count   (session_count),
		.session_window  (session_window),
		.result          (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			result_s2 <= result;
		end
	end

	assign out_valid        = valid_s2;
	assign boundary_kind    = result_s2.kind;
	assign boundary_seconds = result_s2.seconds;
	assign session_number   = result_s2.number;

	// An accepted item always lands in the input register
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted item did not reach the input register");

	// Backpressure only when both registers are full and the output stalls
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && !out_ready)
		else $error("input stalled while the pipeline had room");

	// A stalled input item moves to the result register once the output drains
	a_drain_moves_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && out_ready |=> valid_s2)
		else $error("result register emptied while an item was waiting");

endmodule

// File: hw/rtl/tsnb_cfg.sv
// Configuration registers: session count and the daily session windows.
// Depends on tsnb_pkg.
`timescale 1ns / 1ps

module tsnb_cfg
	import tsnb_pkg::*;
#(
	parameter int MAX_SESSIONS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [WINDOW_W-1:0]  cfg_data,
	output logic [COUNT_W-1:0]   session_count,
	output logic [WINDOW_W-1:0]  session_window [MAX_SESSIONS]
);

	logic [COUNT_W-1:0]  session_count_q;
	logic [WINDOW_W-1:0] window_q [MAX_SESSIONS];

	// Store the session count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_count_q <= SESSION_COUNT_RESET;
		end else if (cfg_write && cfg_index == REG_SESSION_COUNT) begin
			session_count_q <= cfg_data[COUNT_W-1:0];
		end
	end

	// Store one window per session; writes past the table are dropped
	for (genvar k = 0; k < MAX_SESSIONS; k++) begin : g_window
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				window_q[k] <= WINDOW_RESET;
			end else if (cfg_write && cfg_index == REG_SESSION_WINDOW_0 + REG_IDX_W'(k)) begin
				window_q[k] <= cfg_data;
			end
		end
		assign session_window[k] = window_q[k];
	end

	assign session_count = session_count_q;

endmodule

// File: hw/rtl/tsnb_eval.sv
// Single-pass search for the next session boundary of one item.
// Depends on tsnb_pkg.
`timescale 1ns / 1ps

module tsnb_eval
	import tsnb_pkg::*;
#(
	parameter int MAX_SESSIONS = 4
) (
	input  logic [SECONDS_W-1:0] now_seconds,
	input  logic [SECONDS_W-1:0] midnight_seconds,
	input  logic [DAY_W-1:0]     weekday,
	input  logic [COUNT_W-1:0]   session_count,
	input  logic [WINDOW_W-1:0]  session_window [MAX_SESSIONS],
	output result_t              result
);

	logic [COUNT_W-1:0]   count_eff;
	logic [SECONDS_W-1:0] open_at  [MAX_SESSIONS];
	logic [SECONDS_W-1:0] close_at [MAX_SESSIONS];
	logic                 open_hit [MAX_SESSIONS];
	logic                 close_hit[MAX_SESSIONS];
	logic [SECONDS_W-1:0] fallback_at;

	// Clamp the session count to the table size
	assign count_eff = (session_count > COUNT_W'(MAX_SESSIONS)) ? COUNT_W'(MAX_SESSIONS)
	                                                             : session_count;

	// Compare every session against now in parallel
	always_comb begin
		for (int i = 0; i < MAX_SESSIONS; i++) begin
			open_at[i]   = midnight_seconds
			             + SECONDS_W'(minute_offset(start_minute(session_window[i])));
			close_at[i]  = midnight_seconds
			             + SECONDS_W'(minute_offset(stop_minute(session_window[i])));
			open_hit[i]  = (COUNT_W'(i) < count_eff) && (now_seconds < open_at[i]);
			close_hit[i] = (COUNT_W'(i) < count_eff) && (now_seconds < close_at[i]);
		end
	end

	// Open of session 0 on the next weekday
	assign fallback_at = midnight_seconds + SECONDS_W'(next_weekday_offset(weekday))
	                   + SECONDS_W'(minute_offset(start_minute(session_window[0])));

	// On a weekday pick the first session in index order with a boundary ahead; else use the fallback
	always_comb begin
		result.kind    = KIND_OPEN;
		result.seconds = fallback_at;
		result.number  = '0;
		if (is_weekday(weekday)) begin
			for (int i = MAX_SESSIONS - 1; i >= 0; i--) begin
				if (open_hit[i]) begin
					result.kind    = KIND_OPEN;
					result.seconds = open_at[i];
					result.number  = SESSION_W'(i);
				end else if (close_hit[i]) begin
					result.kind    = KIND_CLOSE;
					result.seconds = close_at[i];
					result.number  = SESSION_W'(i);
				end
			end
		end
	end

endmodule

// File: verif/trading_session_next_boundary_tb.sv
// Self-checking testbench for trading_session_next_boundary: a scoreboard class
// predicts each boundary and checks the results. Depends on tsnb_pkg and the RTL.
`timescale 1ns / 1ps

module trading_session_next_boundary_tb;
	import tsnb_pkg::*;

	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned SINK_HOLD   = 80;
	localparam int unsigned PHASES      = 10;
	localparam int unsigned PHASE_ITEMS = 100;
	localparam logic [WINDOW_W-1:0]  MAX_WINDOW = '1;
	localparam logic [DAY_W-1:0]     DAY_UNUSED = 3'd7;
	localparam logic [DAY_W-1:0]     DAY_TUESDAY  = 3'd2;
	localparam logic [DAY_W-1:0]     DAY_WEDNESDAY = 3'd3;
	localparam logic [DAY_W-1:0]     DAY_THURSDAY = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_FIRST_SPARE = REG_SESSION_WINDOW_0 + 3'd4;

	// Predict the next boundary and hold the expected results in order
	class boundary_scoreboard;
		logic [COUNT_W-1:0]  count;
		logic [WINDOW_W-1:0] window [4];
		result_t             pending_boundaries [$];
		int unsigned         mismatches;
		int unsigned         checked;

		function new();
			count = SESSION_COUNT_RESET;
			foreach (window[i]) window[i] = WINDOW_RESET;
			mismatches = 0;
			checked = 0;
		endfunction

		function void write_register(logic [REG_IDX_W-1:0] idx, logic [WINDOW_W-1:0] data);
			if (idx == REG_SESSION_COUNT) begin
				count = data[COUNT_W-1:0];
			end else if (idx >= REG_SESSION_WINDOW_0 && idx < REG_SESSION_WINDOW_0 + 4) begin
				window[idx - REG_SESSION_WINDOW_0] = data;
			end
		endfunction

		function result_t next_boundary(logic [SECONDS_W-1:0] now, logic [SECONDS_W-1:0] mid,
				logic [DAY_W-1:0] day);
			result_t              r;
			logic [SECONDS_W-1:0] open_at;
			logic [SECONDS_W-1:0] close_at;
			int unsigned          used;
			int unsigned          ahead;
			int unsigned          d;
			bit                   found;
			used = (count > 4) ? 4 : count;
			found = 0;
			r.kind = KIND_OPEN;
			r.number = '0;
			r.seconds = '0;
			// scan sessions in index order on weekdays
			if (day >= DAY_MONDAY && day <= DAY_FRIDAY) begin
				for (int i = 0; i < used && !found; i++) begin
					open_at = mid + SECONDS_W'(window[i][WINDOW_W-1:MINUTE_W]) * MINUTE_SECONDS;
					close_at = mid + SECONDS_W'(window[i][MINUTE_W-1:0]) * MINUTE_SECONDS;
					if (now < open_at) begin
						r.kind = KIND_OPEN;
						r.seconds = open_at;
						r.number = SESSION_W'(i);
						found = 1;
					end else if (now < close_at) begin
						r.kind = KIND_CLOSE;
						r.seconds = close_at;
						r.number = SESSION_W'(i);
						found = 1;
					end
				end
			end
			// fall back to session 0 open on the next weekday
			if (!found) begin
				ahead = 1;
				for (int k = 6; k >= 1; k--) begin
					d = (day + k) % 7;
					if (d >= DAY_MONDAY && d <= DAY_FRIDAY) ahead = k;
				end
				r.kind = KIND_OPEN;
				r.number = '0;
				r.seconds = mid + SECONDS_W'(ahead) * DAY_SECONDS
					+ SECONDS_W'(window[0][WINDOW_W-1:MINUTE_W]) * MINUTE_SECONDS;
			end
			return r;
		endfunction

		function void note_item(logic [SECONDS_W-1:0] now, logic [SECONDS_W-1:0] mid,
				logic [DAY_W-1:0] day);
			pending_boundaries.push_back(next_boundary(now, mid, day));
		endfunction

		function void check_result(logic kind, logic [SECONDS_W-1:0] seconds,
				logic [SESSION_W-1:0] number);
			result_t want;
			checked++;
			if (pending_boundaries.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with nothing expected: kind %0d seconds %h number %0d",
						checked, kind, seconds, number);
				return;
			end
			want = pending_boundaries.pop_front();
			if (want.kind !== kind || want.seconds !== seconds || want.number !== number) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d mismatch: kind %0d/%0d seconds %h/%h number %0d/%0d (exp/got)",
						checked, want.kind, kind, want.seconds, seconds, want.number, number);
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [WINDOW_W-1:0]  cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [SECONDS_W-1:0] now_seconds = '0;
	logic [SECONDS_W-1:0] midnight_seconds = '0;
	logic [DAY_W-1:0]     weekday = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 boundary_kind;
	logic [SECONDS_W-1:0] boundary_seconds;
	logic [SESSION_W-1:0] session_number;

	boundary_scoreboard boundaries = new();
	int unsigned handshakes = 0;
	int unsigned items_sent = 0;
	int unsigned settings_loaded = 0;
	int unsigned src_idle_pct = 0;
	int unsigned sink_idle_pct = 0;
	bit          sink_hold_req = 0;

	trading_session_next_boundary u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.now_seconds      (now_seconds),
		.midnight_seconds (midnight_seconds),
		.weekday          (weekday),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.boundary_kind    (boundary_kind),
		.boundary_seconds (boundary_seconds),
		.session_number   (session_number)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Note accepted items and check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				boundaries.note_item(now_seconds, midnight_seconds, weekday);
				handshakes++;
			end
			if (out_valid && out_ready) begin
				boundaries.check_result(boundary_kind, boundary_seconds, session_number);
				handshakes++;
			end
		end
	end

	// Drive out_ready: long hold-off on request, else random stall bursts
	initial begin : result_sink
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (sink_hold_req) begin
				sink_hold_req = 0;
				out_ready <= 1'b0;
				repeat (SINK_HOLD) @(posedge clk);
			end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// End the run when no handshake happens for too long
	initial begin : watchdog
		int unsigned quiet_cycles;
		int unsigned last_moves;
		quiet_cycles = 0;
		last_moves = 0;
		wait (arst_n);
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (handshakes != last_moves) begin
				last_moves = handshakes;
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	// Offer one item, with an optional gap first; hold until accepted
	task automatic send_item(input logic [SECONDS_W-1:0] now, input logic [SECONDS_W-1:0] mid,
			input logic [DAY_W-1:0] day);
		if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		now_seconds <= now;
		midnight_seconds <= mid;
		weekday <= day;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// Stop offering and wait until every expected result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (boundaries.pending_boundaries.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write every register, plus one spare index that must be ignored
	task automatic load_schedule(input logic [COUNT_W-1:0] count, input logic [WINDOW_W-1:0] w0,
			input logic [WINDOW_W-1:0] w1, input logic [WINDOW_W-1:0] w2,
			input logic [WINDOW_W-1:0] w3);
		logic [WINDOW_W-1:0]  data [6];
		logic [REG_IDX_W-1:0] idx [6];
		data[0] = WINDOW_W'($urandom);
		data[0][COUNT_W-1:0] = count;
		data[1] = w0;
		data[2] = w1;
		data[3] = w2;
		data[4] = w3;
		data[5] = WINDOW_W'($urandom);
		idx[0] = REG_SESSION_COUNT;
		for (int i = 1; i < 5; i++) idx[i] = REG_SESSION_WINDOW_0 + REG_IDX_W'(i - 1);
		idx[5] = REG_FIRST_SPARE + REG_IDX_W'($urandom_range(0, 2));
		for (int i = 0; i < 6; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= data[i];
			boundaries.write_register(idx[i], data[i]);
			@(posedge clk);
		end
		cfg_write <= 1'b0;
		@(posedge clk);
		settings_loaded++;
	endtask

	function automatic logic [WINDOW_W-1:0] random_window();
		logic [MINUTE_W-1:0] start;
		logic [MINUTE_W-1:0] stop;
		start = MINUTE_W'($urandom_range(0, 1380));
		stop = start + MINUTE_W'($urandom_range(1, 1439 - start));
		case ($urandom_range(0, 9))
			0: return '0;
			1: return MAX_WINDOW;
			2: return WINDOW_W'($urandom);
			3: return {stop, start};
			default: return {start, stop};
		endcase
	endfunction

	function automatic logic [COUNT_W-1:0] random_count();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return COUNT_W'($urandom_range(5, 7));
			default: return COUNT_W'($urandom_range(1, 4));
		endcase
	endfunction

	// Build an item: mostly weekdays near a configured boundary, some noise
	task automatic random_item(output logic [SECONDS_W-1:0] now, output logic [SECONDS_W-1:0] mid,
			output logic [DAY_W-1:0] day);
		int unsigned         mode;
		logic [WINDOW_W-1:0] w;
		logic [MINUTE_W-1:0] minute;
		mode = $urandom_range(0, 9);
		mid = ($urandom_range(0, 3) == 0) ? SECONDS_W'(32'hFFFF_FFFF - $urandom_range(0, 200000))
			: SECONDS_W'($urandom);
		day = DAY_W'($urandom_range(DAY_MONDAY, DAY_FRIDAY));
		if (mode < 6) begin
			w = boundaries.window[$urandom_range(0, 3)];
			minute = $urandom_range(0, 1) ? w[WINDOW_W-1:MINUTE_W] : w[MINUTE_W-1:0];
			now = mid + SECONDS_W'(minute) * MINUTE_SECONDS + SECONDS_W'($urandom_range(0, 2))
				- SECONDS_W'(1);
		end else if (mode < 8) begin
			day = DAY_W'($urandom_range(0, 7));
			now = mid + SECONDS_W'($urandom_range(0, 100000));
		end else begin
			now = SECONDS_W'($urandom);
			mid = SECONDS_W'($urandom);
			day = DAY_W'($urandom_range(0, 7));
		end
	endtask

	initial begin : stimulus
		logic [SECONDS_W-1:0] now;
		logic [SECONDS_W-1:0] mid;
		logic [DAY_W-1:0]     day;
		logic [SECONDS_W-1:0] m;
		bit                   failed;
		m = 32'd1_700_000_000;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset schedule: one session at minute zero
		send_item(m + 5, m, DAY_MONDAY);
		send_item(m, m, DAY_SATURDAY);
		drain_results();

		// directed: ordered, unordered and out-of-range sessions
		load_schedule(3'd4, {11'd570, 11'd960}, {11'd1000, 11'd1100}, {11'd300, 11'd200},
			MAX_WINDOW);
		send_item(m, m, DAY_MONDAY);
		send_item(m + 570 * 60 - 1, m, DAY_TUESDAY);
		send_item(m + 570 * 60, m, DAY_WEDNESDAY);
		send_item(m + 960 * 60 - 1, m, DAY_THURSDAY);
		send_item(m + 960 * 60, m, DAY_FRIDAY);
		send_item(m + 1100 * 60, m, DAY_MONDAY);
		send_item(m + 2047 * 60 - 1, m, DAY_TUESDAY);
		send_item(m + 2047 * 60, m, DAY_FRIDAY);
		send_item('0, '0, DAY_SUNDAY);
		send_item('0, '0, DAY_SATURDAY);
		send_item('0, '0, DAY_UNUSED);
		send_item('1, '1, DAY_MONDAY);
		send_item('0, 32'hFFFF_0000, DAY_WEDNESDAY);
		send_item('1, '0, DAY_FRIDAY);
		drain_results();

		// directed: no sessions, then a count above the table size
		load_schedule(3'd0, {11'd600, 11'd700}, '0, '0, '0);
		send_item(m, m, DAY_MONDAY);
		send_item(m, m, DAY_UNUSED);
		drain_results();
		load_schedule(3'd7, {11'd60, 11'd120}, {11'd180, 11'd240}, {11'd300, 11'd360},
			{11'd420, 11'd480});
		send_item(m + 400 * 60, m, DAY_THURSDAY);
		send_item(m + 480 * 60, m, DAY_FRIDAY);
		drain_results();

		// random phases, each under a fresh schedule
		for (int phase = 0; phase < PHASES; phase++) begin
			drain_results();
			case (phase)
				0: load_schedule(3'd7, MAX_WINDOW, MAX_WINDOW, MAX_WINDOW, MAX_WINDOW);
				1: load_schedule(3'd0, random_window(), random_window(), random_window(),
					random_window());
				default: load_schedule(random_count(), random_window(), random_window(),
					random_window(), random_window());
			endcase
			if (phase == PHASES - 1) begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end else begin
				src_idle_pct = 20 * $urandom_range(0, 2);
				sink_idle_pct = 20 * $urandom_range(0, 2);
			end
			// hold off the sink and keep pushing until input stalls
			if (phase == 2) begin
				src_idle_pct = 0;
				sink_hold_req = 1;
				repeat (30) begin
					random_item(now, mid, day);
					send_item(now, mid, day);
				end
				src_idle_pct = 20;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				random_item(now, mid, day);
				send_item(now, mid, day);
				if (phase == 4 && n == PHASE_ITEMS / 2) drain_results();
			end
		end

		drain_results();
		repeat (10) @(posedge clk);
		failed = boundaries.mismatches != 0 || boundaries.pending_boundaries.size() != 0;
		$display("run covered %0d items and %0d results under %0d register settings",
			items_sent, boundaries.checked, settings_loaded);
		$display("incl. weekends, weekday 7, session counts 0 to 7, wrapped sums, stalls");
		if (!failed) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches, %0d results missing", boundaries.mismatches,
				boundaries.pending_boundaries.size());
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/tsnb_pkg.sv
hw/rtl/tsnb_cfg.sv
hw/rtl/tsnb_eval.sv
hw/rtl/trading_session_next_boundary.sv
verif/trading_session_next_boundary_tb.sv
